### rtl/write_back_hash_cache_core_assert.svh
// Assertion macros used by the cache core RTL.
`ifndef WRITE_BACK_HASH_CACHE_CORE_ASSERT_SVH
`define WRITE_BACK_HASH_CACHE_CORE_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define WBHC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cache assertion failed");

// The consequent holds in the cycle after the antecedent.
`define WBHC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cache assertion failed");

`endif

### rtl/wbhc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wbhc_pkg
// Types and constants of the write-back hash cache.
// ----------------------------------------------------------------------------
package wbhc_pkg;

  localparam int ENTRIES   = 64;
  localparam int HASH_BITS = 256;
  localparam int SLOT_W    = $clog2(ENTRIES);
  localparam int FILL_W    = $clog2(ENTRIES + 1);
  localparam int LIMIT_W   = 7;
  localparam int IDX_W     = 32;
  localparam int CNT_W     = 32;
  localparam int WORD_W    = 64;
  localparam int ROW_W     = 4 * WORD_W;

  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_FILL  = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;
  localparam logic [1:0] FUNC_FLUSH = 2'd3;

  localparam logic [2:0] ST_HIT       = 3'd0;
  localparam logic [2:0] ST_MISS      = 3'd1;
  localparam logic [2:0] ST_DONE      = 3'd2;
  localparam logic [2:0] ST_WRITEBACK = 3'd3;
  localparam logic [2:0] ST_CLEAN     = 3'd4;

  localparam logic [ROW_W-1:0] HASH_MASK = ROW_W'({HASH_BITS{1'b1}});

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] cnt;
    logic             dirty;
  } entry_t;

  typedef struct packed {
    logic             load;
    logic             bump;
    logic             set_dirty;
    logic             clr_dirty;
    logic [IDX_W-1:0] key;
  } cell_cmd_t;

endpackage
`default_nettype wire

### rtl/wbhc_intf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wbhc_intf
// Request and response channels of the write-back hash cache.
// ----------------------------------------------------------------------------
interface wbhc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] node_index;
  logic [63:0] data_w0;
  logic [63:0] data_w1;
  logic [63:0] data_w2;
  logic [63:0] data_w3;
  modport source (output valid, func, node_index, data_w0, data_w1, data_w2, data_w3,
                  input ready);
  modport sink (input valid, func, node_index, data_w0, data_w1, data_w2, data_w3,
                output ready);
endinterface

interface wbhc_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] out_index;
  logic [63:0] out_w0;
  logic [63:0] out_w1;
  logic [63:0] out_w2;
  logic [63:0] out_w3;
  modport source (output valid, status, out_index, out_w0, out_w1, out_w2, out_w3,
                  input ready);
  modport sink (input valid, status, out_index, out_w0, out_w1, out_w2, out_w3,
                output ready);
endinterface
`default_nettype wire

### rtl/write_back_hash_cache_core.sv
// Flow: an accepted request runs through S_SCAN, in which the tag cell ring
// rotates past the compare point one slot per cycle, then S_READ and S_DONE.
// A new request is taken only in S_IDLE, after the previous response is emitted.
// Reset: synchronous, active high; clears the fill count, all dirty marks and
// the handshake state, and sets the entry limit to 64. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// write_back_hash_cache_core
// Fully associative write-back cache of hash rows with least-used eviction.
// ----------------------------------------------------------------------------
`include "write_back_hash_cache_core_assert.svh"
module write_back_hash_cache_core import wbhc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [LIMIT_W-1:0] cfg_wdata,
  wbhc_req_if.sink                req,
  wbhc_rsp_if.source              rsp
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]         state;
  logic [SLOT_W-1:0]  step;
  logic [LIMIT_W-1:0] limit;
  logic [FILL_W-1:0]  filled;

  logic [1:0]         op_func;
  logic [IDX_W-1:0]   op_key;
  logic [ROW_W-1:0]   op_data;

  logic               hit;
  logic [SLOT_W-1:0]  hit_slot;
  logic [CNT_W-1:0]   min_cnt;
  logic [SLOT_W-1:0]  min_slot;
  logic               min_dirty;
  logic [IDX_W-1:0]   min_idx;
  logic               dfound;
  logic [SLOT_W-1:0]  dslot;
  logic [IDX_W-1:0]   didx;

  logic [2:0]         res_status;
  logic [IDX_W-1:0]   res_idx;
  logic               res_hash;
  logic               res_wr;
  logic [SLOT_W-1:0]  res_slot;

  entry_t             cells [ENTRIES];
  logic               shift;
  logic               fire_in;
  logic               emit;
  logic               slot_ok;
  entry_t             head;

  logic [2:0]         dec_status;
  logic [IDX_W-1:0]   dec_idx;
  logic               dec_hash;
  logic               dec_wr;
  logic [SLOT_W-1:0]  dec_slot;
  logic               dec_meta;
  logic               dec_grow;
  cell_cmd_t          cmd;
  logic [LIMIT_W-1:0] eff_limit;
  logic [ROW_W-1:0]   rdata;

  assign req.ready = (state == S_IDLE);
  assign fire_in   = req.valid && req.ready;
  assign shift     = (state == S_SCAN);
  assign emit      = (state == S_DONE) && (!rsp.valid || rsp.ready);
  assign head      = cells[0];
  assign slot_ok   = {1'b0, step} < filled;

  genvar gi;
  generate
    for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
      wbhc_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (shift),
        .nbr   (cells[(gi + 1) % ENTRIES]),
        .sel   (dec_meta && (dec_slot == SLOT_W'(gi))),
        .cmd   (cmd),
        .q     (cells[gi])
      );
    end
  endgenerate

  always_comb begin
    if (limit == '0) begin
      eff_limit = LIMIT_W'(1);
    end else if (limit > LIMIT_W'(ENTRIES)) begin
      eff_limit = LIMIT_W'(ENTRIES);
    end else begin
      eff_limit = limit;
    end
  end

  always_comb begin
    dec_status    = ST_DONE;
    dec_idx       = '0;
    dec_hash      = 1'b0;
    dec_wr        = 1'b0;
    dec_slot      = hit_slot;
    dec_meta      = 1'b0;
    dec_grow      = 1'b0;
    cmd.load      = 1'b0;
    cmd.bump      = 1'b0;
    cmd.set_dirty = 1'b0;
    cmd.clr_dirty = 1'b0;
    cmd.key       = op_key;
    if (state == S_READ) begin
      unique case (op_func)
        FUNC_FLUSH: begin
          if (dfound) begin
            dec_status    = ST_WRITEBACK;
            dec_idx       = didx;
            dec_hash      = 1'b1;
            dec_slot      = dslot;
            dec_meta      = 1'b1;
            cmd.clr_dirty = 1'b1;
          end else begin
            dec_status = ST_CLEAN;
          end
        end
        FUNC_READ: begin
          dec_idx = op_key;
          if (hit) begin
            dec_status = ST_HIT;
            dec_hash   = 1'b1;
            dec_meta   = 1'b1;
            cmd.bump   = 1'b1;
          end else begin
            dec_status = ST_MISS;
          end
        end
        FUNC_FILL, FUNC_WRITE: begin
          if (hit) begin
            if (op_func == FUNC_WRITE) begin
              dec_wr        = 1'b1;
              dec_meta      = 1'b1;
              cmd.bump      = 1'b1;
              cmd.set_dirty = 1'b1;
            end
          end else begin
            dec_wr        = 1'b1;
            dec_meta      = 1'b1;
            cmd.load      = 1'b1;
            cmd.set_dirty = (op_func == FUNC_WRITE);
            if (filled < FILL_W'(eff_limit)) begin
              dec_slot = filled[SLOT_W-1:0];
              dec_grow = 1'b1;
            end else begin
              dec_slot = min_slot;
              if (min_dirty) begin
                dec_status = ST_WRITEBACK;
                dec_idx    = min_idx;
                dec_hash   = 1'b1;
              end
            end
          end
        end
        default: begin
          dec_status = ST_DONE;
        end
      endcase
    end
  end

  wbhc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (emit && res_wr),
    .waddr (res_slot),
    .wdata (op_data),
    .raddr ((state == S_READ) ? dec_slot : res_slot),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      limit     <= LIMIT_W'(ENTRIES);
      filled    <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit <= cfg_wdata;
      end
      if (emit) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          step <= '0;
          if (fire_in) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          step <= step + SLOT_W'(1);
          if (step == SLOT_W'(ENTRIES - 1)) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          if (dec_grow) begin
            filled <= filled + FILL_W'(1);
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (emit) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fire_in) begin
      op_func <= req.func;
      op_key  <= req.node_index;
      op_data <= {req.data_w3, req.data_w2, req.data_w1, req.data_w0} & HASH_MASK;
      hit     <= 1'b0;
      dfound  <= 1'b0;
    end
    if (shift && slot_ok) begin
      if (!hit && (head.idx == op_key)) begin
        hit      <= 1'b1;
        hit_slot <= step;
      end
      if ((step == '0) || (head.cnt < min_cnt)) begin
        min_cnt   <= head.cnt;
        min_slot  <= step;
        min_dirty <= head.dirty;
        min_idx   <= head.idx;
      end
      if (!dfound && head.dirty) begin
        dfound <= 1'b1;
        dslot  <= step;
        didx   <= head.idx;
      end
    end
    if (state == S_READ) begin
      res_status <= dec_status;
      res_idx    <= dec_idx;
      res_hash   <= dec_hash;
      res_wr     <= dec_wr;
      res_slot   <= dec_slot;
    end
    if (emit) begin
      rsp.status    <= res_status;
      rsp.out_index <= res_idx;
      rsp.out_w0    <= res_hash ? rdata[63:0]    : '0;
      rsp.out_w1    <= res_hash ? rdata[127:64]  : '0;
      rsp.out_w2    <= res_hash ? rdata[191:128] : '0;
      rsp.out_w3    <= res_hash ? rdata[255:192] : '0;
    end
  end

  `WBHC_ASSERT_NOW(a_fill_bound, 1'b1, filled <= FILL_W'(ENTRIES))
  `WBHC_ASSERT_NEXT(a_scan_end, (state == S_SCAN) && (step == SLOT_W'(ENTRIES - 1)),
                    state == S_READ)
  `WBHC_ASSERT_NEXT(a_emit, emit, rsp.valid && (state == S_IDLE))

endmodule
`default_nettype wire

### rtl/wbhc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wbhc_ram
// Simple dual-port RAM with a registered read.
// ----------------------------------------------------------------------------
module wbhc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/wbhc_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wbhc_cell
// One slot of tag state; rotates to its neighbor during a scan.
// ----------------------------------------------------------------------------
module wbhc_cell import wbhc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      shift,
  input  wire entry_t    nbr,
  input  wire logic      sel,
  input  wire cell_cmd_t cmd,
  output entry_t         q
);

  entry_t q_next;

  always_comb begin
    q_next = q;
    if (shift) begin
      q_next = nbr;
    end else if (sel) begin
      if (cmd.load) begin
        q_next.idx   = cmd.key;
        q_next.cnt   = '0;
        q_next.dirty = cmd.set_dirty;
      end else begin
        if (cmd.bump && (q.cnt != '1)) begin
          q_next.cnt = q.cnt + CNT_W'(1);
        end
        if (cmd.set_dirty) begin
          q_next.dirty = 1'b1;
        end
        if (cmd.clr_dirty) begin
          q_next.dirty = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    q.idx <= q_next.idx;
    q.cnt <= q_next.cnt;
    if (rst) begin
      q.dirty <= 1'b0;
    end else begin
      q.dirty <= q_next.dirty;
    end
  end

endmodule
`default_nettype wire
